FILE: sv/page_cache_translator_defines.svh
`ifndef PAGE_CACHE_TRANSLATOR_DEFINES_SVH
`define PAGE_CACHE_TRANSLATOR_DEFINES_SVH

// Both macros expect signals named clk and rst in the enclosing scope.
// The check is disabled while reset is held.

// Same-cycle implication.
`define PCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define PCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pct_pkg.sv
`default_nettype none

package pct_pkg;

  localparam int TARGET_PAGES_DEF = 256;
  localparam int CACHE_PAGES_DEF  = 256;
  localparam int PAGE_W           = 8;

  localparam logic [PAGE_W-1:0] LAST_PAGE_RESET = 8'd15;
  localparam logic [PAGE_W-1:0] NO_PAGE         = 8'hFF;
  localparam logic [PAGE_W-1:0] NO_SLOT         = 8'hFF;

  // Target page status.
  localparam logic [1:0] ST_UNALLOC  = 2'd0;
  localparam logic [1:0] ST_RESIDENT = 2'd1;
  localparam logic [1:0] ST_PAGED    = 2'd2;

  // Result outcome codes.
  localparam logic [1:0] OUTCOME_HIT   = 2'd0;
  localparam logic [1:0] OUTCOME_NEW   = 2'd1;
  localparam logic [1:0] OUTCOME_FETCH = 2'd2;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] location;
    logic [PAGE_W-1:0] slot;
    logic              slot_valid;
  } map_entry_t;

  localparam map_entry_t MAP_RESET = '{
    status:     ST_UNALLOC,
    location:   NO_PAGE,
    slot:       NO_SLOT,
    slot_valid: 1'b0
  };

  typedef struct packed {
    logic              re;
    logic [PAGE_W-1:0] raddr;
    logic              we;
    logic [PAGE_W-1:0] waddr;
    map_entry_t        wdata;
  } map_req_t;

endpackage

`default_nettype wire

FILE: sv/page_cache_translator.sv
// Paged cache address translator.
// Input channel: target_address under in_valid / in_stall. Output channel:
// cache_address, outcome, write_back, victim_target_page, victim_slot and
// fetch_slot under out_valid / out_stall. Exactly one result per transaction.
// A transaction enters in the idle state; the page map and the cache owner
// table are read in that cycle and their data arrive in the cycle after.
// A hit or a miss that finds a free cache page finishes in the lookup state.
// A miss that evicts reads the victim's map entry in the lookup state and
// finishes in the evict state, where that entry is marked paged.
// The result sits in an output register; the next transaction is accepted
// while it waits. A transaction that reaches its lookup step while the output
// register is still stalled waits there, writing nothing, until it is taken.
// Synchronous reset empties the cache, marks every target page unallocated,
// clears the victim pointer and slot counter and sets last_cache_page to 15.
// The configuration register is written with cfg_we and cfg_wdata, and
// should only be written while no transaction is in flight.
`default_nettype none

module page_cache_translator import pct_pkg::*; #(
  parameter int TARGET_PAGES = TARGET_PAGES_DEF,
  parameter int CACHE_PAGES  = CACHE_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] target_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] cache_address,
  output logic [1:0]  outcome,
  output logic        write_back,
  output logic [7:0]  victim_target_page,
  output logic [7:0]  victim_slot,
  output logic [7:0]  fetch_slot
);

  localparam int CNT_W = $clog2(CACHE_PAGES) + 1;
  localparam logic [PAGE_W-1:0] LAST_MAX = PAGE_W'(CACHE_PAGES - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_EVICT  = 2'd2;

  logic [1:0]        state;
  logic [PAGE_W-1:0] last_cache_page;
  logic [PAGE_W-1:0] victim_pointer;
  logic [PAGE_W-1:0] next_slot;
  logic [CNT_W-1:0]  alloc_count;

  logic [PAGE_W-1:0] page_q;
  logic [7:0]        offset_q;
  logic [PAGE_W-1:0] cpage_q;
  logic [1:0]        outcome_q;
  logic [PAGE_W-1:0] fslot_q;

  logic [PAGE_W-1:0] page_mod [256];
  logic [PAGE_W-1:0] page_idx;
  logic [PAGE_W-1:0] eff_last;
  logic [PAGE_W-1:0] vp_use;
  logic [PAGE_W-1:0] new_cpage;
  logic [PAGE_W-1:0] evict_slot;
  logic [PAGE_W-1:0] miss_fslot;
  logic [1:0]        miss_outcome;
  logic              hit;
  logic              has_free;
  logic              go;

  map_req_t          map_req;
  map_entry_t        map_rdata;
  logic              owner_re;
  logic              owner_we;
  logic [PAGE_W-1:0] owner_rdata;

  // Page numbers beyond the map fold back through a constant table.
  for (genvar g = 0; g < 256; g++) begin : g_page_mod
    assign page_mod[g] = PAGE_W'(g % TARGET_PAGES);
  end

  assign page_idx = page_mod[target_address[15:8]];
  assign eff_last = (last_cache_page > LAST_MAX) ? LAST_MAX : last_cache_page;
  assign vp_use   = (victim_pointer > eff_last) ? '0 : victim_pointer;

  // Allocation always takes the lowest free page and pages are never freed,
  // so the allocated pages form a prefix and a count describes them fully.
  assign has_free  = 9'(alloc_count) <= {1'b0, eff_last};
  assign new_cpage = has_free ? PAGE_W'(alloc_count) : vp_use;

  assign hit          = map_rdata.status == ST_RESIDENT;
  assign miss_outcome = (map_rdata.status == ST_PAGED) ? OUTCOME_FETCH : OUTCOME_NEW;
  assign miss_fslot   = (map_rdata.status == ST_PAGED) ? map_rdata.slot : '0;
  assign evict_slot   = map_rdata.slot_valid ? map_rdata.slot : next_slot;

  assign go       = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;

  always_comb begin
    map_req  = '0;
    owner_re = 1'b0;
    owner_we = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          map_req.re    = 1'b1;
          map_req.raddr = page_idx;
          owner_re      = 1'b1;
        end
      end
      S_LOOKUP: begin
        if (go && !hit) begin
          map_req.we                  = 1'b1;
          map_req.waddr               = page_q;
          map_req.wdata.status        = ST_RESIDENT;
          map_req.wdata.location      = new_cpage;
          map_req.wdata.slot          = map_rdata.slot;
          map_req.wdata.slot_valid    = map_rdata.slot_valid;
          owner_we                    = 1'b1;
          if (!has_free) begin
            // The victim's owner differs from the requested page, which is
            // not resident, so this read never meets the write above.
            map_req.re    = 1'b1;
            map_req.raddr = owner_rdata;
          end
        end
      end
      S_EVICT: begin
        if (go) begin
          map_req.we               = 1'b1;
          map_req.waddr            = owner_rdata;
          map_req.wdata.status     = ST_PAGED;
          map_req.wdata.location   = NO_PAGE;
          map_req.wdata.slot       = evict_slot;
          map_req.wdata.slot_valid = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      last_cache_page <= LAST_PAGE_RESET;
      victim_pointer  <= '0;
      next_slot       <= '0;
      alloc_count     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        last_cache_page <= cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (go) begin
            if (hit || has_free) begin
              out_valid <= 1'b1;
              state     <= S_IDLE;
              if (!hit) begin
                alloc_count <= alloc_count + CNT_W'(1);
              end
            end else begin
              victim_pointer <= vp_use + 8'd1;
              state          <= S_EVICT;
            end
          end
        end
        S_EVICT: begin
          if (go) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (!map_rdata.slot_valid) begin
              next_slot <= next_slot + 8'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      page_q   <= page_idx;
      offset_q <= target_address[7:0];
    end
    if (state == S_LOOKUP && go) begin
      if (hit || has_free) begin
        cache_address      <= {(hit ? map_rdata.location : new_cpage), offset_q};
        outcome            <= hit ? OUTCOME_HIT : miss_outcome;
        write_back         <= 1'b0;
        victim_target_page <= '0;
        victim_slot        <= '0;
        fetch_slot         <= hit ? '0 : miss_fslot;
      end else begin
        cpage_q   <= vp_use;
        outcome_q <= miss_outcome;
        fslot_q   <= miss_fslot;
      end
    end
    if (state == S_EVICT && go) begin
      cache_address      <= {cpage_q, offset_q};
      outcome            <= outcome_q;
      write_back         <= 1'b1;
      victim_target_page <= owner_rdata;
      victim_slot        <= evict_slot;
      fetch_slot         <= fslot_q;
    end
  end

  pct_map_store #(
    .TARGET_PAGES(TARGET_PAGES)
  ) u_map (
    .clk   (clk),
    .rst   (rst),
    .req   (map_req),
    .rdata (map_rdata)
  );

  pct_owner_store #(
    .CACHE_PAGES(CACHE_PAGES)
  ) u_owner (
    .clk   (clk),
    .re    (owner_re),
    .raddr (vp_use),
    .we    (owner_we),
    .waddr (new_cpage),
    .wdata (page_q),
    .rdata (owner_rdata)
  );

endmodule

`default_nettype wire

FILE: sv/pct_owner_store.sv
`default_nettype none

module pct_owner_store import pct_pkg::*; #(
  parameter int CACHE_PAGES = CACHE_PAGES_DEF
) (
  input  logic              clk,
  input  logic              re,
  input  logic [PAGE_W-1:0] raddr,
  input  logic              we,
  input  logic [PAGE_W-1:0] waddr,
  input  logic [PAGE_W-1:0] wdata,
  output logic [PAGE_W-1:0] rdata
);

  localparam int IDX_W = $clog2(CACHE_PAGES);

  logic [PAGE_W-1:0] mem [CACHE_PAGES];
  logic [IDX_W-1:0]  ridx;
  logic [IDX_W-1:0]  widx;

  assign ridx = raddr[IDX_W-1:0];
  assign widx = waddr[IDX_W-1:0];

  // An entry's data is only used once its cache page has been allocated, so the
  // array needs no clearing.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[widx] <= wdata;
    end
    if (re) begin
      rdata <= mem[ridx];
    end
  end

endmodule

`default_nettype wire

FILE: sv/pct_map_store.sv
`default_nettype none

module pct_map_store import pct_pkg::*; #(
  parameter int TARGET_PAGES = TARGET_PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  map_req_t   req,
  output map_entry_t rdata
);

  localparam int IDX_W = $clog2(TARGET_PAGES);

  map_entry_t              mem [TARGET_PAGES];
  map_entry_t              mem_q;
  logic [TARGET_PAGES-1:0] written;
  logic                    written_q;
  logic [IDX_W-1:0]        ridx;
  logic [IDX_W-1:0]        widx;

  assign ridx = req.raddr[IDX_W-1:0];
  assign widx = req.waddr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[widx] <= req.wdata;
    end
    if (req.re) begin
      mem_q <= mem[ridx];
    end
  end

  // One flag per entry stands in for clearing the array at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (req.we) begin
        written[widx] <= 1'b1;
      end
      if (req.re) begin
        written_q <= written[ridx];
      end
    end
  end

  assign rdata = written_q ? mem_q : MAP_RESET;

endmodule

`default_nettype wire

FILE: sv/pct_checker.sv
`default_nettype none
`include "page_cache_translator_defines.svh"

module pct_checker import pct_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] cache_address,
  input wire logic [1:0]  outcome,
  input wire logic        write_back,
  input wire logic [7:0]  victim_target_page,
  input wire logic [7:0]  victim_slot,
  input wire logic [7:0]  fetch_slot
);

  // A hit touches no backing store.
  `PCT_ASSERT_NOW(a_hit_clean, out_valid && outcome == OUTCOME_HIT, !write_back && victim_target_page == 8'd0 && victim_slot == 8'd0 && fetch_slot == 8'd0, "hit reports backing store traffic")

  `PCT_ASSERT_NOW(a_fetch_only, out_valid && outcome != OUTCOME_FETCH, fetch_slot == 8'd0, "fetch slot set without a fetch")

  // One transaction at a time: the input side is busy right after a transaction.
  `PCT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "transaction accepted back to back")

  `PCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cache_address) && $stable(outcome), "stalled result changed")

endmodule

bind page_cache_translator pct_checker u_pct_checker (.*);

`default_nettype wire
